### design/dnsx_pkg.sv
// Shared types and constants for the DNS reply A-record extractor.
`default_nettype none

package dnsx_pkg;

  localparam int unsigned DATA_W       = 8;
  localparam int unsigned ADDR_W       = 32;
  localparam int unsigned TTL_W        = 32;
  localparam int unsigned OFFSET_W     = 16;
  localparam int unsigned COUNT_W      = 16;
  // Four fields plus the status bit, padded up to whole bytes.
  localparam int unsigned RESULT_BITS  = ADDR_W + TTL_W + OFFSET_W + COUNT_W + 1;
  localparam int unsigned TDATA_W      = ((RESULT_BITS + 7) / 8) * 8;

  localparam int unsigned QUEUE_DEPTH  = 4;
  localparam int unsigned QPTR_W       = $clog2(QUEUE_DEPTH);

  localparam logic [15:0] POINTER_BASE = 16'hc000;
  localparam logic [15:0] TYPE_A       = 16'h0001;
  localparam logic [3:0]  HEADER_LEN   = 4'd12;

  localparam logic KIND_ANSWER  = 1'b0;
  localparam logic KIND_SUMMARY = 1'b1;

  typedef struct packed {
    logic                kind;
    logic [ADDR_W-1:0]   ipv4_address;
    logic [TTL_W-1:0]    time_to_live;
    logic [OFFSET_W-1:0] name_offset;
    logic [COUNT_W-1:0]  answer_number;
    logic                status;
    logic                last;
  } result_t;

  // Results produced by one input byte: count is 0, 1 or 2.
  typedef struct packed {
    logic [1:0] count;
    result_t    first;
    result_t    second;
  } push_t;

endpackage

`default_nettype wire

### design/dns_reply_a_record_extractor.sv
// Top level of the DNS reply A-record extractor.
`default_nettype none

// Takes a DNS reply one byte per request on the slave stream, with tlast on the
// final byte, and gives its results on the master stream: an answer result for
// every type-A record, and a summary with the completion status when the
// message ends. The parser takes one byte per clock cycle while there is room;
// its results are registered in the queue before they reach the master side.
// Results leave through a four-entry queue at one per cycle while m_tready is
// high, and the slave side holds tready low while fewer than two entries are
// free, so a stalled master side stalls the input. A byte that both ends an A
// answer and the message yields two results, answer first.
module dns_reply_a_record_extractor (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      s_tvalid,
  output logic                           s_tready,
  input  wire logic [7:0]                s_tdata,   // [7:0] data_byte
  input  wire logic                      s_tlast,   // end_of_message
  output logic                           m_tvalid,
  input  wire logic                      m_tready,
  // [31:0] ipv4_address, [63:32] time_to_live, [79:64] name_offset,
  // [95:80] answer_number, [96] status, upper bits zero
  output logic [dnsx_pkg::TDATA_W-1:0]   m_tdata,
  output logic                           m_tuser,   // result_kind
  output logic                           m_tlast    // last
);
  import dnsx_pkg::*;

  push_t   push;
  result_t head;
  logic    room;
  logic    take;

  assign s_tready = room;
  assign take     = s_tvalid && room;

  dnsx_parse u_parse (
    .clk            (clk),
    .rst            (rst),
    .take           (take),
    .data_byte      (s_tdata),
    .end_of_message (s_tlast),
    .push           (push)
  );

  dnsx_outq u_outq (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .room  (room),
    .valid (m_tvalid),
    .ready (m_tready),
    .head  (head)
  );

  assign m_tdata = {(TDATA_W - RESULT_BITS)'(0), head.status, head.answer_number,
                    head.name_offset, head.time_to_live, head.ipv4_address};
  assign m_tuser = head.kind;
  assign m_tlast = head.last;

endmodule

`default_nettype wire

### design/dnsx_parse.sv
// Byte-wide DNS reply parser: header, question skip and answer field capture.
`default_nettype none

module dnsx_parse (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          take,
  input  wire logic [7:0]    data_byte,
  input  wire logic          end_of_message,
  output dnsx_pkg::push_t    push
);
  import dnsx_pkg::*;

  localparam logic [3:0] PH_HEADER = 4'd0;
  localparam logic [3:0] PH_QLEN   = 4'd1;
  localparam logic [3:0] PH_QLABEL = 4'd2;
  localparam logic [3:0] PH_QTAIL  = 4'd3;
  localparam logic [3:0] PH_ANAME  = 4'd4;
  localparam logic [3:0] PH_ATYPE  = 4'd5;
  localparam logic [3:0] PH_ACLASS = 4'd6;
  localparam logic [3:0] PH_ATTL   = 4'd7;
  localparam logic [3:0] PH_ARDLEN = 4'd8;
  localparam logic [3:0] PH_ARDATA = 4'd9;
  localparam logic [3:0] PH_DONE   = 4'd10;

  logic [3:0]  parse_phase,      parse_phase_next;
  logic [3:0]  field_byte_count, field_byte_count_next;
  logic [15:0] answer_total,     answer_total_next;
  logic [15:0] answers_done,     answers_done_next;
  logic [7:0]  label_bytes_left, label_bytes_left_next;
  logic [15:0] rdata_bytes_left, rdata_bytes_left_next;
  logic [15:0] record_type,      record_type_next;
  logic [15:0] pointer_accum,    pointer_accum_next;
  logic [31:0] ttl_accum,        ttl_accum_next;
  logic [31:0] address_accum,    address_accum_next;

  logic [3:0]  count_inc;
  logic [15:0] done_inc;
  logic [7:0]  label_dec;
  logic [15:0] rdata_dec;
  logic [15:0] rdlen_shift;
  logic        finish;
  logic        a_hit;
  result_t     answer_res;
  result_t     summary_res;

  always_comb begin
    count_inc             = field_byte_count + 4'd1;
    done_inc              = answers_done + 16'd1;
    label_dec             = label_bytes_left - 8'd1;
    rdata_dec             = rdata_bytes_left - 16'd1;
    rdlen_shift           = {rdata_bytes_left[7:0], data_byte};
    finish                = 1'b0;

    parse_phase_next      = parse_phase;
    field_byte_count_next = field_byte_count;
    answer_total_next     = answer_total;
    answers_done_next     = answers_done;
    label_bytes_left_next = label_bytes_left;
    rdata_bytes_left_next = rdata_bytes_left;
    record_type_next      = record_type;
    pointer_accum_next    = pointer_accum;
    ttl_accum_next        = ttl_accum;
    address_accum_next    = address_accum;

    unique case (parse_phase)
      PH_HEADER: begin
        if (field_byte_count == 4'd6) begin
          answer_total_next = {data_byte, 8'h00};
        end else if (field_byte_count == 4'd7) begin
          answer_total_next = {answer_total[15:8], data_byte};
        end
        field_byte_count_next = count_inc;
        if (count_inc >= HEADER_LEN) begin
          field_byte_count_next = 4'd0;
          parse_phase_next      = PH_QLEN;
        end
      end
      PH_QLEN: begin
        if (data_byte == 8'h00) begin
          field_byte_count_next = 4'd0;
          parse_phase_next      = PH_QTAIL;
        end else begin
          label_bytes_left_next = data_byte;
          parse_phase_next      = PH_QLABEL;
        end
      end
      PH_QLABEL: begin
        label_bytes_left_next = label_dec;
        if (label_dec == 8'd0) begin
          parse_phase_next = PH_QLEN;
        end
      end
      PH_QTAIL: begin
        field_byte_count_next = count_inc;
        if (count_inc >= 4'd4) begin
          field_byte_count_next = 4'd0;
          parse_phase_next      = (answer_total == 16'd0) ? PH_DONE : PH_ANAME;
        end
      end
      PH_ANAME: begin
        pointer_accum_next    = {pointer_accum[7:0], data_byte};
        field_byte_count_next = count_inc;
        if (count_inc >= 4'd2) begin
          field_byte_count_next = 4'd0;
          parse_phase_next      = PH_ATYPE;
        end
      end
      PH_ATYPE: begin
        record_type_next      = {record_type[7:0], data_byte};
        field_byte_count_next = count_inc;
        if (count_inc >= 4'd2) begin
          field_byte_count_next = 4'd0;
          parse_phase_next      = PH_ACLASS;
        end
      end
      PH_ACLASS: begin
        field_byte_count_next = count_inc;
        if (count_inc >= 4'd2) begin
          field_byte_count_next = 4'd0;
          parse_phase_next      = PH_ATTL;
        end
      end
      PH_ATTL: begin
        ttl_accum_next        = {ttl_accum[23:0], data_byte};
        field_byte_count_next = count_inc;
        if (count_inc >= 4'd4) begin
          field_byte_count_next = 4'd0;
          parse_phase_next      = PH_ARDLEN;
        end
      end
      PH_ARDLEN: begin
        rdata_bytes_left_next = rdlen_shift;
        field_byte_count_next = count_inc;
        if (count_inc >= 4'd2) begin
          field_byte_count_next = 4'd0;
          address_accum_next    = 32'd0;
          // An empty rdata closes the answer here, with a zero address.
          if (rdlen_shift == 16'd0) begin
            finish = 1'b1;
          end else begin
            parse_phase_next = PH_ARDATA;
          end
        end
      end
      PH_ARDATA: begin
        // Only the first four rdata bytes land in the address; the rest are skipped.
        if (field_byte_count < 4'd4) begin
          case (field_byte_count[1:0])
            2'd0:    address_accum_next[31:24] = address_accum[31:24] | data_byte;
            2'd1:    address_accum_next[23:16] = address_accum[23:16] | data_byte;
            2'd2:    address_accum_next[15:8]  = address_accum[15:8]  | data_byte;
            default: address_accum_next[7:0]   = address_accum[7:0]   | data_byte;
          endcase
          field_byte_count_next = count_inc;
        end
        rdata_bytes_left_next = rdata_dec;
        if (rdata_dec == 16'd0) begin
          finish = 1'b1;
        end
      end
      default: begin
      end
    endcase

    a_hit = finish && (record_type == TYPE_A);

    answer_res.kind          = KIND_ANSWER;
    answer_res.ipv4_address  = address_accum_next;
    answer_res.time_to_live  = ttl_accum;
    answer_res.name_offset   = pointer_accum - POINTER_BASE;
    answer_res.answer_number = answers_done;
    answer_res.status        = 1'b0;
    answer_res.last          = !end_of_message;

    if (finish) begin
      answers_done_next     = done_inc;
      field_byte_count_next = 4'd0;
      parse_phase_next      = (done_inc == answer_total) ? PH_DONE : PH_ANAME;
    end

    summary_res.kind          = KIND_SUMMARY;
    summary_res.ipv4_address  = '0;
    summary_res.time_to_live  = '0;
    summary_res.name_offset   = '0;
    summary_res.answer_number = answers_done_next;
    summary_res.status        = (parse_phase_next != PH_DONE);
    summary_res.last          = 1'b1;

    // The answer result, when there is one, always goes first.
    push.count  = {1'b0, a_hit} + {1'b0, end_of_message};
    push.first  = a_hit ? answer_res : summary_res;
    push.second = summary_res;
    if (!take) begin
      push.count = 2'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      parse_phase      <= PH_HEADER;
      field_byte_count <= '0;
      answer_total     <= '0;
      answers_done     <= '0;
      label_bytes_left <= '0;
      rdata_bytes_left <= '0;
      record_type      <= '0;
      pointer_accum    <= '0;
      ttl_accum        <= '0;
      address_accum    <= '0;
    end else if (take) begin
      if (end_of_message) begin
        // The message is over: everything goes back to its reset value.
        parse_phase      <= PH_HEADER;
        field_byte_count <= '0;
        answer_total     <= '0;
        answers_done     <= '0;
        label_bytes_left <= '0;
        rdata_bytes_left <= '0;
        record_type      <= '0;
        pointer_accum    <= '0;
        ttl_accum        <= '0;
        address_accum    <= '0;
      end else begin
        parse_phase      <= parse_phase_next;
        field_byte_count <= field_byte_count_next;
        answer_total     <= answer_total_next;
        answers_done     <= answers_done_next;
        label_bytes_left <= label_bytes_left_next;
        rdata_bytes_left <= rdata_bytes_left_next;
        record_type      <= record_type_next;
        pointer_accum    <= pointer_accum_next;
        ttl_accum        <= ttl_accum_next;
        address_accum    <= address_accum_next;
      end
    end
  end

endmodule

`default_nettype wire

### design/dnsx_outq.sv
// Small result queue: up to two results in per cycle, one out while ready.
`default_nettype none

module dnsx_outq (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire dnsx_pkg::push_t push,
  output logic               room,
  output logic               valid,
  input  wire logic          ready,
  output dnsx_pkg::result_t  head
);
  import dnsx_pkg::*;

  result_t             entries [QUEUE_DEPTH];
  logic [QPTR_W-1:0]   wr_ptr;
  logic [QPTR_W-1:0]   rd_ptr;
  logic [QPTR_W:0]     count;
  logic [QPTR_W-1:0]   wr_ptr_plus;
  logic                pop;

  assign wr_ptr_plus = wr_ptr + 1'b1;
  assign pop         = valid && ready;
  assign valid       = (count != '0);
  assign head        = entries[rd_ptr];
  // Room for two results is needed before another byte is taken.
  assign room        = (count <= (QPTR_W+1)'(QUEUE_DEPTH - 2));

  always_ff @(posedge clk) begin
    if (push.count != 2'd0) begin
      entries[wr_ptr] <= push.first;
    end
    if (push.count == 2'd2) begin
      entries[wr_ptr_plus] <= push.second;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + QPTR_W'(push.count);
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      count <= count + (QPTR_W+1)'(push.count) - (QPTR_W+1)'(pop);
    end
  end

endmodule

`default_nettype wire

### tb/dnsx_checker.sv
// Checker for the DNS reply A-record extractor: it predicts the results and compares them.
`timescale 1ns / 100ps

module dnsx_checker (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_tvalid,
  input  logic                           s_tready,
  input  logic [7:0]                     s_tdata,   // [7:0] data_byte
  input  logic                           s_tlast,   // end_of_message
  input  logic                           m_tvalid,
  input  logic                           m_tready,
  // [31:0] ipv4_address, [63:32] time_to_live, [79:64] name_offset,
  // [95:80] answer_number, [96] status, upper bits zero
  input  logic [dnsx_pkg::TDATA_W-1:0]   m_tdata,
  input  logic                           m_tuser,   // result_kind
  input  logic                           m_tlast,   // last
  output int                             fail_count,
  output int                             pending,
  output int                             answers_seen,
  output int                             summaries_seen,
  output int                             truncations_seen
);

  import dnsx_pkg::*;

  typedef enum logic [3:0] {
    P_HEADER, P_QLEN, P_QLABEL, P_QTAIL, P_PTR, P_TYPE,
    P_CLASS, P_TTL, P_RDLEN, P_RDATA, P_DONE
  } phase_t;

  phase_t      phase;
  logic [3:0]  field_pos;
  logic [15:0] answer_total;
  logic [15:0] answers_done;
  logic [7:0]  label_left;
  logic [15:0] rdata_left;
  logic [15:0] rec_type;
  logic [15:0] name_ptr;
  logic [31:0] ttl_acc;
  logic [31:0] addr_acc;

  result_t     step_out [2];
  int          step_n;
  result_t     expected_results [$];

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    fail_count++;
    $display("%0t: mismatch in %s: got %0h, expected %0h", $time, what, got, want);
  endtask

  function automatic result_t make_result(input logic kind, input logic [31:0] ip,
                                          input logic [31:0] ttl, input logic [15:0] off,
                                          input logic [15:0] num, input logic st);
    result_t r;
    r.kind          = kind;
    r.ipv4_address  = ip;
    r.time_to_live  = ttl;
    r.name_offset   = off;
    r.answer_number = num;
    r.status        = st;
    r.last          = 1'b0;
    return r;
  endfunction

  task automatic clear_parser();
    phase        = P_HEADER;
    field_pos    = '0;
    answer_total = '0;
    answers_done = '0;
    label_left   = '0;
    rdata_left   = '0;
    rec_type     = '0;
    name_ptr     = '0;
    ttl_acc      = '0;
    addr_acc     = '0;
  endtask

  // An answer is over: only type A yields a result, but every answer counts.
  task automatic close_answer();
    if (rec_type == TYPE_A) begin
      step_out[step_n] = make_result(KIND_ANSWER, addr_acc, ttl_acc,
                                     name_ptr - POINTER_BASE, answers_done, 1'b0);
      step_n++;
    end
    answers_done = answers_done + 16'd1;
    field_pos    = '0;
    phase        = (answers_done == answer_total) ? P_DONE : P_PTR;
  endtask

  task automatic parse_byte(input logic [7:0] b, input logic eom);
    step_n = 0;
    case (phase)
      P_HEADER: begin
        if (field_pos == 4'd6)
          answer_total = {b, 8'h00};
        else if (field_pos == 4'd7)
          answer_total = answer_total | {8'h00, b};
        field_pos = field_pos + 4'd1;
        if (field_pos >= HEADER_LEN) begin
          field_pos = '0;
          phase     = P_QLEN;
        end
      end
      P_QLEN: begin
        // Any nonzero byte is a label length, compression pointers included.
        if (b == 8'h00) begin
          field_pos = '0;
          phase     = P_QTAIL;
        end else begin
          label_left = b;
          phase      = P_QLABEL;
        end
      end
      P_QLABEL: begin
        label_left = label_left - 8'd1;
        if (label_left == 8'd0)
          phase = P_QLEN;
      end
      P_QTAIL: begin
        field_pos = field_pos + 4'd1;
        if (field_pos >= 4'd4) begin
          field_pos = '0;
          phase     = (answer_total == 16'd0) ? P_DONE : P_PTR;
        end
      end
      P_PTR: begin
        name_ptr  = {name_ptr[7:0], b};
        field_pos = field_pos + 4'd1;
        if (field_pos >= 4'd2) begin
          field_pos = '0;
          phase     = P_TYPE;
        end
      end
      P_TYPE: begin
        rec_type  = {rec_type[7:0], b};
        field_pos = field_pos + 4'd1;
        if (field_pos >= 4'd2) begin
          field_pos = '0;
          phase     = P_CLASS;
        end
      end
      P_CLASS: begin
        field_pos = field_pos + 4'd1;
        if (field_pos >= 4'd2) begin
          field_pos = '0;
          phase     = P_TTL;
        end
      end
      P_TTL: begin
        ttl_acc   = {ttl_acc[23:0], b};
        field_pos = field_pos + 4'd1;
        if (field_pos >= 4'd4) begin
          field_pos = '0;
          phase     = P_RDLEN;
        end
      end
      P_RDLEN: begin
        rdata_left = {rdata_left[7:0], b};
        field_pos  = field_pos + 4'd1;
        if (field_pos >= 4'd2) begin
          field_pos = '0;
          addr_acc  = '0;
          if (rdata_left == 16'd0)
            close_answer();
          else
            phase = P_RDATA;
        end
      end
      P_RDATA: begin
        // Only the first four rdata bytes form the address.
        if (field_pos < 4'd4) begin
          addr_acc  = addr_acc | ({24'h000000, b} << (24 - 8 * field_pos));
          field_pos = field_pos + 4'd1;
        end
        rdata_left = rdata_left - 16'd1;
        if (rdata_left == 16'd0)
          close_answer();
      end
      default: ;
    endcase
    if (eom) begin
      step_out[step_n] = make_result(KIND_SUMMARY, '0, '0, '0, answers_done,
                                     phase != P_DONE);
      step_n++;
      clear_parser();
    end
    if (step_n > 0)
      step_out[step_n-1].last = 1'b1;
    for (int i = 0; i < step_n; i++)
      expected_results.push_back(step_out[i]);
  endtask

  task automatic check_result();
    result_t e;
    if (expected_results.size() == 0) begin
      report_mismatch("result with no request pending", m_tdata[31:0], '0);
    end else begin
      e = expected_results.pop_front();
      if (m_tuser !== e.kind)
        report_mismatch("result_kind", 32'(m_tuser), 32'(e.kind));
      if (m_tdata[31:0] !== e.ipv4_address)
        report_mismatch("ipv4_address", m_tdata[31:0], e.ipv4_address);
      if (m_tdata[63:32] !== e.time_to_live)
        report_mismatch("time_to_live", m_tdata[63:32], e.time_to_live);
      if (m_tdata[79:64] !== e.name_offset)
        report_mismatch("name_offset", 32'(m_tdata[79:64]), 32'(e.name_offset));
      if (m_tdata[95:80] !== e.answer_number)
        report_mismatch("answer_number", 32'(m_tdata[95:80]), 32'(e.answer_number));
      if (m_tdata[96] !== e.status)
        report_mismatch("status", 32'(m_tdata[96]), 32'(e.status));
      if (m_tdata[TDATA_W-1:RESULT_BITS] !== '0)
        report_mismatch("tdata padding", 32'(m_tdata[TDATA_W-1:RESULT_BITS]), '0);
      if (m_tlast !== e.last)
        report_mismatch("last", 32'(m_tlast), 32'(e.last));
      if (e.kind == KIND_SUMMARY) begin
        summaries_seen++;
        if (e.status)
          truncations_seen++;
      end else begin
        answers_seen++;
      end
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      clear_parser();
      expected_results.delete();
    end else begin
      if (s_tvalid && s_tready)
        parse_byte(s_tdata, s_tlast);
      if (m_tvalid && m_tready)
        check_result();
    end
    pending <= expected_results.size();
  end

endmodule

### tb/dns_reply_a_record_extractor_tb.sv
// Testbench top for the DNS reply A-record extractor: stimulus, stalls and verdict.
`timescale 1ns / 100ps

module dns_reply_a_record_extractor_tb;

  import dnsx_pkg::*;

  typedef enum int {MSG_WELL, MSG_SURPLUS, MSG_TRUNC, MSG_NOISE} msg_kind_t;

  logic               clk;
  logic               rst;
  logic               s_tvalid;
  logic               s_tready;
  logic [7:0]         s_tdata;
  logic               s_tlast;
  logic               m_tvalid;
  logic               m_tready;
  logic [TDATA_W-1:0] m_tdata;
  logic               m_tuser;
  logic               m_tlast;

  int fail_count;
  int pending;
  int answers_seen;
  int summaries_seen;
  int truncations_seen;

  bit         src_gaps;
  bit         sink_gaps;
  int         hold_requests;
  int         bytes_sent;
  int         messages_sent;
  logic [7:0] msg_bytes [$];

  dns_reply_a_record_extractor i_dut (.*);

  dnsx_checker i_checker (.*);

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Receiver: random back-pressure, plus a long hold-off whenever one is requested.
  initial begin
    int holds_served;
    int hold_left;
    holds_served = 0;
    hold_left    = 0;
    m_tready     = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_requests != holds_served) begin
        holds_served = hold_requests;
        hold_left    = 300;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= !sink_gaps || ($urandom_range(99) >= 16);
      end
    end
  end

  initial begin
    #5_000_000;
    $display("Timed out with %0d results outstanding.", pending);
    $display("== FAIL ==");
    $finish;
  end

  function automatic logic [7:0] rand_byte();
    return 8'($urandom_range(255));
  endfunction

  task automatic send_byte(input logic [7:0] b, input logic eom);
    while (src_gaps && $urandom_range(99) < 16) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= b;
    s_tlast  <= eom;
    do @(posedge clk); while (!s_tready);
  endtask

  task automatic send_message();
    for (int i = 0; i < msg_bytes.size(); i++) begin
      send_byte(msg_bytes[i], i == msg_bytes.size() - 1);
      bytes_sent++;
    end
    messages_sent++;
  endtask

  // Builds one reply: header, one question, answers, then an ending that the kind
  // chooses; noise is random bytes. Most replies are well formed to reach answers.
  task automatic build_message(input msg_kind_t kind);
    int          n_ans;
    int          n_labels;
    int          len;
    int          cut;
    logic [15:0] ancount;
    logic [15:0] rdlen;
    msg_bytes.delete();
    if (kind == MSG_NOISE) begin
      len = $urandom_range(1, 40);
      repeat (len) msg_bytes.push_back(rand_byte());
    end else begin
      n_ans   = ($urandom_range(9) == 0) ? 0 : $urandom_range(1, 3);
      ancount = 16'(n_ans);
      if (kind == MSG_TRUNC && $urandom_range(3) == 0)
        ancount = $urandom_range(1) ? 16'hffff : 16'($urandom_range(65535));
      for (int i = 0; i < 12; i++) begin
        if (i == 6)
          msg_bytes.push_back(ancount[15:8]);
        else if (i == 7)
          msg_bytes.push_back(ancount[7:0]);
        else
          msg_bytes.push_back(rand_byte());
      end
      n_labels = $urandom_range(0, 3);
      repeat (n_labels) begin
        len = ($urandom_range(19) == 0) ? $urandom_range(64, 255) : $urandom_range(1, 6);
        msg_bytes.push_back(8'(len));
        repeat (len) msg_bytes.push_back(rand_byte());
      end
      msg_bytes.push_back(8'h00);
      repeat (4) msg_bytes.push_back(rand_byte());
      repeat (n_ans) begin
        if ($urandom_range(1)) begin
          msg_bytes.push_back(8'hc0);
          msg_bytes.push_back(8'h0c);
        end else begin
          msg_bytes.push_back(rand_byte());
          msg_bytes.push_back(rand_byte());
        end
        if ($urandom_range(99) < 70) begin
          msg_bytes.push_back(8'h00);
          msg_bytes.push_back(8'h01);
        end else begin
          msg_bytes.push_back(rand_byte());
          msg_bytes.push_back(rand_byte());
        end
        repeat (6) msg_bytes.push_back(rand_byte());
        len = $urandom_range(99);
        if (len < 70)
          rdlen = 16'd4;
        else if (len < 90)
          rdlen = 16'($urandom_range(0, 8));
        else if (len < 97 || kind != MSG_TRUNC)
          rdlen = 16'($urandom_range(9, 40));
        else
          rdlen = 16'($urandom_range(65535)) | 16'hff00;
        msg_bytes.push_back(rdlen[15:8]);
        msg_bytes.push_back(rdlen[7:0]);
        // A huge rdata length is only sent in a reply that is cut short anyway.
        len = (rdlen > 16'd40) ? 24 : rdlen;
        repeat (len) msg_bytes.push_back(rand_byte());
      end
      if (kind == MSG_SURPLUS) begin
        len = $urandom_range(1, 4);
        repeat (len) msg_bytes.push_back(rand_byte());
      end else if (kind == MSG_TRUNC) begin
        cut       = $urandom_range(1, msg_bytes.size() - 1);
        msg_bytes = msg_bytes[0:cut-1];
      end
    end
  endtask

  initial begin
    int        pick;
    int        waited;
    msg_kind_t kind;
    rst           = 1'b1;
    s_tvalid      = 1'b0;
    s_tdata       = 8'h00;
    s_tlast       = 1'b0;
    src_gaps      = 1'b1;
    sink_gaps     = 1'b1;
    hold_requests = 0;
    bytes_sent    = 0;
    messages_sent = 0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // A reply that ends on its first byte, then one whose only answer is type A
    // with empty rdata and ends on the same byte as the reply.
    msg_bytes = '{8'hff};
    send_message();
    msg_bytes = '{8'h12, 8'h34, 8'h81, 8'h80, 8'h00, 8'h01, 8'h00, 8'h01,
                  8'h00, 8'h00, 8'h00, 8'h00,
                  8'h01, 8'h61, 8'h00, 8'h00, 8'h01, 8'h00, 8'h01,
                  8'hff, 8'hff, 8'h00, 8'h01, 8'h00, 8'h01,
                  8'hff, 8'hff, 8'hff, 8'hff, 8'h00, 8'h00};
    send_message();

    while (bytes_sent < 1800) begin
      pick = $urandom_range(99);
      if (pick < 60)
        kind = MSG_WELL;
      else if (pick < 75)
        kind = MSG_SURPLUS;
      else if (pick < 90)
        kind = MSG_TRUNC;
      else
        kind = MSG_NOISE;
      build_message(kind);
      // A long receiver hold-off while requests keep coming fills the block up.
      if (messages_sent == 4)
        hold_requests <= hold_requests + 1;
      src_gaps = !(messages_sent >= 8 && messages_sent < 14);
      sink_gaps <= !(messages_sent >= 8 && messages_sent < 14);
      if (messages_sent == 16) begin
        s_tvalid <= 1'b0;
        @(posedge clk);
        wait (pending == 0);
        @(posedge clk);
      end
      send_message();
    end
    s_tvalid <= 1'b0;
    s_tlast  <= 1'b0;

    waited = 0;
    while (pending != 0 && waited < 20000) begin
      @(posedge clk);
      waited++;
    end
    repeat (16) @(posedge clk);

    $display("Sent %0d replies in %0d request bytes: well formed, with surplus bytes,",
             messages_sent, bytes_sent);
    $display("cut short and noise; checked %0d A results and %0d summaries (%0d truncated).",
             answers_seen, summaries_seen, truncations_seen);
    if (pending != 0)
      $display("%0d expected results never arrived.", pending);
    if (fail_count == 0 && pending == 0)
      $display("== PASS ==");
    else
      $display("== FAIL ==");
    $finish;
  end

endmodule

### sim.f
design/dnsx_pkg.sv
design/dnsx_parse.sv
design/dnsx_outq.sv
design/dns_reply_a_record_extractor.sv
tb/dnsx_checker.sv
tb/dns_reply_a_record_extractor_tb.sv
